FILE: src/tdm_pkg.sv
package tdm_pkg;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Control from the sequencer to the serial units
   typedef struct packed {
      logic load;
      logic step;
   } step_ctrl_type;

   // Thermal levels
   localparam logic [1:0] LVL_NORMAL   = 2'd0;
   localparam logic [1:0] LVL_WARNING  = 2'd1;
   localparam logic [1:0] LVL_CRITICAL = 2'd2;
   localparam logic [1:0] LVL_SHUTDOWN = 2'd3;

   // Register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WARNING   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CRITICAL  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHUTDOWN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HYSTERESIS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SMOOTHING = 3'd4;

   // Register reset values
   localparam int WARNING_RESET    = 1120;
   localparam int CRITICAL_RESET   = 1360;
   localparam int SHUTDOWN_RESET   = 1600;
   localparam int HYSTERESIS_RESET = 80;
   localparam logic [15:0] SMOOTHING_RESET = 16'd6554;

   // Fixed point and serial unit geometry
   localparam int unsigned FRAC_BITS    = 16;
   localparam int unsigned FACTOR_BITS  = 16;
   localparam int unsigned SERIAL_STEPS = FACTOR_BITS + 1;
   localparam int unsigned STEP_BITS    = 5;
   localparam int unsigned QUOT_BITS    = SERIAL_STEPS;

   // Power in 1/256 percent
   localparam int unsigned POWER_BITS = 15;
   localparam logic [POWER_BITS-1:0] POWER_FULL = 15'd25600;
   localparam logic [POWER_BITS-1:0] POWER_HALF = 15'd12800;
   localparam logic [POWER_BITS-1:0] POWER_NONE = 15'd0;

endpackage

FILE: src/tdm_if.sv
interface tdm_req_if #(
   parameter int TEMP_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [TEMP_BITS-1:0] temperature;

   modport source (output valid, output temperature, input ready);
   modport sink   (input valid, input temperature, output ready);
endinterface

interface tdm_rsp_if import tdm_pkg::*; #(
   parameter int TEMP_BITS  = 16,
   parameter int COUNT_BITS = 32
);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  level;
   logic [POWER_BITS-1:0]       allowed_power;
   logic signed [TEMP_BITS-1:0] average_temperature;
   logic [TEMP_BITS-2:0]        peak_temperature;
   logic                        derating_on;
   logic                        safe;
   logic                        shutdown_needed;
   logic [COUNT_BITS-1:0]       warning_entries;
   logic [COUNT_BITS-1:0]       critical_entries;
   logic [COUNT_BITS-1:0]       shutdown_entries;

   modport source (
      output valid, output level, output allowed_power, output average_temperature,
      output peak_temperature, output derating_on, output safe, output shutdown_needed,
      output warning_entries, output critical_entries, output shutdown_entries,
      input ready
   );
   modport sink (
      input valid, input level, input allowed_power, input average_temperature,
      input peak_temperature, input derating_on, input safe, input shutdown_needed,
      input warning_entries, input critical_entries, input shutdown_entries,
      output ready
   );
endinterface

FILE: src/tdm_smul.sv
// Bit-serial signed x unsigned multiplier, factor bits taken MSB first
module tdm_smul import tdm_pkg::*; #(
   parameter int TEMP_BITS = 16,
   localparam int DBits = TEMP_BITS + FRAC_BITS + 1,
   localparam int PBits = DBits + FACTOR_BITS
) (
   input  logic                    clock,
   input  step_ctrl_type           ctrl,
   input  logic signed [DBits-1:0] diff,
   input  logic [FACTOR_BITS-1:0]  factor,
   output logic signed [PBits-1:0] product
);

   logic [DBits-1:0]       diff_ff;
   logic [FACTOR_BITS:0]   fac_ff;
   logic [FACTOR_BITS:0]   fac_in;
   logic [PBits-1:0]       acc_ff;
   logic [PBits-1:0]       acc_in;
   logic [PBits-1:0]       addend;

   // One factor bit per cycle while ctrl.step is high: acc = 2*acc + bit*diff
   always_comb begin
      addend = fac_ff[FACTOR_BITS] ? {{FACTOR_BITS{diff_ff[DBits-1]}}, diff_ff} : '0;
      acc_in = {acc_ff[PBits-2:0], 1'b0} + addend;
      fac_in = {fac_ff[FACTOR_BITS-1:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         diff_ff <= diff;
         fac_ff  <= {1'b0, factor};
         acc_ff  <= '0;
      end else if (ctrl.step) begin
         fac_ff <= fac_in;
         acc_ff <= acc_in;
      end
   end

   assign product = signed'(acc_ff);

endmodule

FILE: src/tdm_sdiv.sv
// Restoring divider, one quotient bit per cycle while ctrl.step is high.
// Computes (base * POWER_HALF) / divisor; the top quotient bit flags overflow.
module tdm_sdiv import tdm_pkg::*; #(
   parameter int TEMP_BITS = 16,
   localparam int RemBits = TEMP_BITS + 14,
   localparam int DivBits = TEMP_BITS + QUOT_BITS - 1
) (
   input  logic                  clock,
   input  step_ctrl_type         ctrl,
   input  logic [TEMP_BITS-1:0]  base,
   input  logic [TEMP_BITS-1:0]  divisor,
   output logic [QUOT_BITS-1:0]  quotient
);

   logic [RemBits-1:0]   rem_ff;
   logic [DivBits-1:0]   dsh_ff;
   logic [QUOT_BITS-1:0] quot_ff;
   logic                 fits;

   // Trial subtract against the shifted divisor
   assign fits = {{(DivBits-RemBits){1'b0}}, rem_ff} >= dsh_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rem_ff  <= RemBits'(base) * RemBits'(POWER_HALF);
         dsh_ff  <= {divisor, {(QUOT_BITS-1){1'b0}}};
         quot_ff <= '0;
      end else if (ctrl.step) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff[RemBits-1:0];
         end
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[QUOT_BITS-2:0], fits};
      end
   end

   assign quotient = quot_ff;

endmodule

FILE: src/thermal_derating_monitor_core.sv
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   temperature (signed, 1/16 degree)
// rsp_chan  out  valid/ready   level, allowed_power, average/peak temperature,
//                              status flags, entry counters
// csr_*     in   write enable  register index, write data
//
// A request is accepted, then steps the bit-serial average multiplier and
// the shared-counter restoring divider together, then commits.
// The next request is taken once the result sits in the output register; a
// stalled rsp_chan holds the core in its commit cycle until that register frees.
// Reset is synchronous; it restores defaults and clears state but not the payload.
module thermal_derating_monitor_core import tdm_pkg::*; #(
   parameter int TEMP_BITS  = 16,
   parameter int COUNT_BITS = 32,
   localparam int CsrDataBits = (TEMP_BITS > 16) ? TEMP_BITS : 16
) (
   input  logic                      clock,
   input  logic                      reset,
   tdm_req_if.sink                   req_chan,
   tdm_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CsrDataBits-1:0]    csr_write_data
);

   localparam int DBits = TEMP_BITS + FRAC_BITS + 1;
   localparam int PBits = DBits + FACTOR_BITS;

   // Configuration
   logic signed [TEMP_BITS-1:0] warn_lvl_ff;
   logic signed [TEMP_BITS-1:0] crit_lvl_ff;
   logic signed [TEMP_BITS-1:0] shut_lvl_ff;
   logic [TEMP_BITS-2:0]        hyst_ff;
   logic [FACTOR_BITS-1:0]      factor_ff;

   // Core state
   state_type                      state_ff, state_in;
   logic [STEP_BITS-1:0]           cnt_ff;
   logic [1:0]                     level_ff, lvl_in, old_lvl_ff;
   logic                           cw_ok_ff;
   logic signed [TEMP_BITS+15:0]   smooth_ff;
   logic [TEMP_BITS-2:0]           peak_ff;
   logic [COUNT_BITS-1:0]          warn_cnt_ff, crit_cnt_ff, halt_cnt_ff;
   logic                           warn_hit, crit_hit, halt_hit;

   // Output register
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_level_ff;
   logic [POWER_BITS-1:0]       rsp_power_ff;
   logic signed [TEMP_BITS-1:0] rsp_avg_ff;
   logic [TEMP_BITS-2:0]        rsp_peak_ff;
   logic                        rsp_derate_ff, rsp_safe_ff, rsp_shut_ff;
   logic [COUNT_BITS-1:0]       rsp_warn_ff, rsp_crit_ff, rsp_halt_ff;

   // Datapath
   logic                         accept, commit;
   logic signed [TEMP_BITS-1:0]  t;
   logic signed [TEMP_BITS:0]    t_x, w_x, c_x, s_x, h_x, tw, dv;
   logic signed [DBits-1:0]      diff;
   logic [TEMP_BITS-1:0]         div_base;
   logic signed [PBits-1:0]      product, prod_sh;
   logic signed [TEMP_BITS+16:0] smooth_sum;
   logic [QUOT_BITS-1:0]         quot;
   logic [POWER_BITS-1:0]        power;
   step_ctrl_type                ctrl;

   assign t      = req_chan.temperature;
   assign accept = req_chan.valid && req_chan.ready;
   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Operand prep at accept
   always_comb begin
      t_x  = signed'({t[TEMP_BITS-1], t});
      w_x  = signed'({warn_lvl_ff[TEMP_BITS-1], warn_lvl_ff});
      c_x  = signed'({crit_lvl_ff[TEMP_BITS-1], crit_lvl_ff});
      s_x  = signed'({shut_lvl_ff[TEMP_BITS-1], shut_lvl_ff});
      h_x  = signed'({2'b00, hyst_ff});
      tw   = t_x - w_x;
      dv   = c_x - w_x;
      div_base = (tw > 0) ? tw[TEMP_BITS-1:0] : '0;
      diff = signed'({t[TEMP_BITS-1], t, {FRAC_BITS{1'b0}}}) - DBits'(smooth_ff);
   end

   // Level transition, judged against the neighbors of the current level
   always_comb begin
      lvl_in   = level_ff;
      warn_hit = 1'b0;
      crit_hit = 1'b0;
      halt_hit = 1'b0;
      case (level_ff)
         LVL_NORMAL: begin
            if (t_x >= w_x) begin
               lvl_in   = LVL_WARNING;
               warn_hit = 1'b1;
            end
         end
         LVL_WARNING: begin
            if (t_x >= c_x) begin
               lvl_in   = LVL_CRITICAL;
               crit_hit = 1'b1;
            end else if (t_x <= w_x - h_x) begin
               lvl_in = LVL_NORMAL;
            end
         end
         LVL_CRITICAL: begin
            if (t_x >= s_x) begin
               lvl_in   = LVL_SHUTDOWN;
               halt_hit = 1'b1;
            end else if (t_x <= c_x - h_x) begin
               lvl_in = LVL_WARNING;
            end
         end
         default: begin
            lvl_in = level_ff;
         end
      endcase
   end

   // Serial units
   assign ctrl.load = accept;
   assign ctrl.step = (state_ff == ST_CALC);

   tdm_smul #(.TEMP_BITS(TEMP_BITS)) u_smul (
      .clock   (clock),
      .ctrl    (ctrl),
      .diff    (diff),
      .factor  (factor_ff),
      .product (product)
   );

   tdm_sdiv #(.TEMP_BITS(TEMP_BITS)) u_sdiv (
      .clock    (clock),
      .ctrl     (ctrl),
      .base     (div_base),
      .divisor  (dv[TEMP_BITS-1:0]),
      .quotient (quot)
   );

   // Average update and power from the level held before this request
   always_comb begin
      prod_sh    = product >>> FRAC_BITS;
      smooth_sum = (TEMP_BITS+17)'(smooth_ff) + signed'(prod_sh[TEMP_BITS+16:0]);
      case (old_lvl_ff)
         LVL_NORMAL:   power = POWER_FULL;
         LVL_WARNING: begin
            if (!cw_ok_ff) begin
               power = POWER_HALF;
            end else if (quot > QUOT_BITS'(POWER_FULL)) begin
               power = POWER_NONE;
            end else begin
               power = POWER_FULL - quot[POWER_BITS-1:0];
            end
         end
         LVL_CRITICAL: power = POWER_HALF;
         default:      power = POWER_NONE;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CALC;
         ST_CALC: if (cnt_ff == '0) state_in = ST_DONE;
         ST_DONE: if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         level_ff     <= LVL_NORMAL;
         old_lvl_ff   <= LVL_NORMAL;
         cw_ok_ff     <= 1'b0;
         smooth_ff    <= '0;
         peak_ff      <= '0;
         warn_cnt_ff  <= '0;
         crit_cnt_ff  <= '0;
         halt_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            cnt_ff     <= STEP_BITS'(SERIAL_STEPS - 1);
            level_ff   <= lvl_in;
            old_lvl_ff <= level_ff;
            cw_ok_ff   <= (dv > 0);
            if (!t[TEMP_BITS-1] && (t[TEMP_BITS-2:0] > peak_ff)) begin
               peak_ff <= t[TEMP_BITS-2:0];
            end
            if (warn_hit) warn_cnt_ff <= warn_cnt_ff + 1'b1;
            if (crit_hit) crit_cnt_ff <= crit_cnt_ff + 1'b1;
            if (halt_hit) halt_cnt_ff <= halt_cnt_ff + 1'b1;
         end else if (state_ff == ST_CALC) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (commit) begin
            smooth_ff <= smooth_sum[TEMP_BITS+15:0];
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_lvl_ff <= TEMP_BITS'(WARNING_RESET);
         crit_lvl_ff <= TEMP_BITS'(CRITICAL_RESET);
         shut_lvl_ff <= TEMP_BITS'(SHUTDOWN_RESET);
         hyst_ff     <= (TEMP_BITS-1)'(HYSTERESIS_RESET);
         factor_ff   <= SMOOTHING_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_WARNING:    warn_lvl_ff <= signed'(csr_write_data[TEMP_BITS-1:0]);
            REG_CRITICAL:   crit_lvl_ff <= signed'(csr_write_data[TEMP_BITS-1:0]);
            REG_SHUTDOWN:   shut_lvl_ff <= signed'(csr_write_data[TEMP_BITS-1:0]);
            REG_HYSTERESIS: hyst_ff     <= csr_write_data[TEMP_BITS-2:0];
            REG_SMOOTHING:  factor_ff   <= csr_write_data[FACTOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_level_ff  <= level_ff;
         rsp_power_ff  <= power;
         rsp_avg_ff    <= signed'(smooth_sum[TEMP_BITS+15:FRAC_BITS]);
         rsp_peak_ff   <= peak_ff;
         rsp_derate_ff <= (level_ff != LVL_NORMAL);
         rsp_safe_ff   <= (level_ff == LVL_NORMAL) || (level_ff == LVL_WARNING);
         rsp_shut_ff   <= (level_ff == LVL_SHUTDOWN);
         rsp_warn_ff   <= warn_cnt_ff;
         rsp_crit_ff   <= crit_cnt_ff;
         rsp_halt_ff   <= halt_cnt_ff;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.level               = rsp_level_ff;
   assign rsp_chan.allowed_power       = rsp_power_ff;
   assign rsp_chan.average_temperature = rsp_avg_ff;
   assign rsp_chan.peak_temperature    = rsp_peak_ff;
   assign rsp_chan.derating_on         = rsp_derate_ff;
   assign rsp_chan.safe                = rsp_safe_ff;
   assign rsp_chan.shutdown_needed     = rsp_shut_ff;
   assign rsp_chan.warning_entries     = rsp_warn_ff;
   assign rsp_chan.critical_entries    = rsp_crit_ff;
   assign rsp_chan.shutdown_entries    = rsp_halt_ff;

endmodule
